// ===== rtl/rgbc_pkg.sv =====
// rgbc_pkg: shared constants, types and helpers of the rgb 3x3 convolution filter
// used by the interfaces and the top level
`default_nettype none
package rgbc_pkg;
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int PIX_W      = 32;
   localparam int CH_W       = 8;
   localparam int ROW_W      = 24;
   localparam int SUM_W      = 16;
   localparam int DIVR_W     = 8;
   localparam int BIAS_W     = 9;
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [ROW_W-1:0]    KERNEL_LATER_RST  = 24'h000000;
   localparam logic [ROW_W-1:0]    KERNEL_MIDDLE_RST = 24'h000100;
   localparam logic [ROW_W-1:0]    KERNEL_EARLIER_RST = 24'h000000;
   localparam logic [DIVR_W-1:0]   DIVISOR_RST = 8'd1;
   localparam logic [BIAS_W-1:0]   BIAS_RST    = 9'd0;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST   = 12'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_LATER   = 3'd0,
      CSR_KERNEL_MIDDLE  = 3'd1,
      CSR_KERNEL_EARLIER = 3'd2,
      CSR_DIVISOR        = 3'd3,
      CSR_BIAS           = 3'd4,
      CSR_WIDTH          = 3'd5,
      CSR_HEIGHT         = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_DIV,
      ST_OUT
   } state_type;

   function automatic logic signed [7:0] coef(input logic [ROW_W-1:0] row,
                                              input logic [1:0] col);
      logic signed [7:0] c;
      case (col)
         2'd0:    c = row[7:0];
         2'd1:    c = row[15:8];
         2'd2:    c = row[23:16];
         default: c = 8'sd0;
      endcase
      return c;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/rgbc_req_if.sv =====
// rgbc_req_if: pixel input channel and result channel interfaces
// depends on rgbc_pkg for field widths
`default_nettype none
interface rgbc_req_if;
   logic                        valid;
   logic                        ready;
   logic [rgbc_pkg::PIX_W-1:0] pixel_word;
   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface rgbc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rgbc_pkg::CH_W-1:0] out_red;
   logic [rgbc_pkg::CH_W-1:0] out_green;
   logic [rgbc_pkg::CH_W-1:0] out_blue;
   logic                       frame_last;
   modport source (output valid, output out_red, output out_green, output out_blue,
                   output frame_last, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/rgbc_ram.sv =====
// rgbc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module rgbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rgb_conv3x3_filter_unit.sv =====
// rgb_conv3x3_filter_unit: top level of the rgb 3x3 convolution filter
// depends on rgbc_pkg, rgbc_req_if, rgbc_rsp_if and rgbc_ram
//
// One pixel is taken per transfer; the block then reads both line stores, writes
// them back and shifts the window, and for an interior pixel runs nine
// multiply-accumulate steps and a sixteen-step divider shared by nothing but its
// own channel, then loads the output register. An interior pixel may also wait
// for the output register to empty.
// The pixel rate is set by the serial kernel loop and the bit-serial divider.
`default_nettype none
module rgb_conv3x3_filter_unit #(
   parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rgbc_req_if.sink                                 req_port,
   rgbc_rsp_if.source                               rsp_port,
   input  wire logic                                csr_wr_en,
   input  wire logic [rgbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rgbc_pkg::CSR_DATA_W-1:0]    csr_data
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int RWD = rgbc_pkg::ROW_W;

   logic [RWD-1:0]                  k_later_ff, k_middle_ff, k_earlier_ff;
   logic [rgbc_pkg::DIVR_W-1:0]     divisor_ff;
   logic [rgbc_pkg::BIAS_W-1:0]     bias_ff;
   logic [rgbc_pkg::WIDTH_W-1:0]    width_ff;
   logic [rgbc_pkg::HEIGHT_W-1:0]   height_ff;

   rgbc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [RWD-1:0]  px_ff;
   logic [RWD-1:0]  win_ff [2][3];
   logic [RWD-1:0]  opnd_ff [3][3];
   logic            last_ff;
   logic [1:0]      x_ff, y_ff;
   logic [3:0]      step_ff;
   logic [rgbc_pkg::SUM_W-1:0] acc_ff [3];
   logic [rgbc_pkg::SUM_W-1:0] dq_ff [3];
   logic [rgbc_pkg::DIVR_W-1:0] rem_ff [3];
   logic            rsp_valid_ff;
   logic [rgbc_pkg::CH_W-1:0] out_ff [3];
   logic            out_last_ff;

   logic [RWD-1:0]  e_rd, m_rd;
   logic            req_xfer, out_free, rd_en;
   logic [31:0]     w_lim, h_lim;
   logic            last_col, last_row, interior;
   logic [rgbc_pkg::DIVR_W-1:0] d_eff;
   logic [RWD-1:0]  mac_px;
   logic signed [7:0] mac_coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_later_ff   <= rgbc_pkg::KERNEL_LATER_RST;
         k_middle_ff  <= rgbc_pkg::KERNEL_MIDDLE_RST;
         k_earlier_ff <= rgbc_pkg::KERNEL_EARLIER_RST;
         divisor_ff   <= rgbc_pkg::DIVISOR_RST;
         bias_ff      <= rgbc_pkg::BIAS_RST;
         width_ff     <= rgbc_pkg::WIDTH_RST;
         height_ff    <= rgbc_pkg::HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (rgbc_pkg::csr_index_type'(csr_index))
            rgbc_pkg::CSR_KERNEL_LATER:   k_later_ff   <= csr_data;
            rgbc_pkg::CSR_KERNEL_MIDDLE:  k_middle_ff  <= csr_data;
            rgbc_pkg::CSR_KERNEL_EARLIER: k_earlier_ff <= csr_data;
            rgbc_pkg::CSR_DIVISOR:        divisor_ff   <= csr_data[rgbc_pkg::DIVR_W-1:0];
            rgbc_pkg::CSR_BIAS:           bias_ff      <= csr_data[rgbc_pkg::BIAS_W-1:0];
            rgbc_pkg::CSR_WIDTH:          width_ff     <= csr_data[rgbc_pkg::WIDTH_W-1:0];
            rgbc_pkg::CSR_HEIGHT:         height_ff    <= csr_data[rgbc_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_port.ready = (state_ff == rgbc_pkg::ST_IDLE);
   assign req_xfer = req_port.valid && req_port.ready;
   assign rd_en    = req_xfer;
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      w_lim = 32'(width_ff);
      if (w_lim < 32'd3) w_lim = 32'd3;
      if (w_lim > 32'(MAX_WIDTH)) w_lim = 32'(MAX_WIDTH);
      h_lim = 32'(height_ff);
      if (h_lim < 32'd3) h_lim = 32'd3;
      if (h_lim > 32'(MAX_HEIGHT)) h_lim = 32'(MAX_HEIGHT);
   end
   assign last_col = 32'(col_ff) >= (w_lim - 32'd1);
   assign last_row = 32'(row_ff) >= (h_lim - 32'd1);
   assign interior = (32'(col_ff) >= 32'd2) && (32'(row_ff) >= 32'd2);
   assign d_eff    = (divisor_ff == '0) ? rgbc_pkg::DIVR_W'(1) : divisor_ff;

   rgbc_ram #(.WIDTH(RWD), .DEPTH(MAX_WIDTH)) u_earlier (
      .clock(clock), .wr_en(state_ff == rgbc_pkg::ST_READ), .wr_addr(col_ff),
      .wr_data(m_rd), .rd_en(rd_en), .rd_addr(col_ff), .rd_data(e_rd)
   );
   rgbc_ram #(.WIDTH(RWD), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .wr_en(state_ff == rgbc_pkg::ST_READ), .wr_addr(col_ff),
      .wr_data(px_ff), .rd_en(rd_en), .rd_addr(col_ff), .rd_data(m_rd)
   );

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         rgbc_pkg::ST_IDLE: begin
            if (req_xfer) state_in = rgbc_pkg::ST_READ;
         end
         rgbc_pkg::ST_READ: begin
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            state_in = interior ? rgbc_pkg::ST_MAC : rgbc_pkg::ST_IDLE;
         end
         rgbc_pkg::ST_MAC: begin
            if (x_ff == 2'd2 && y_ff == 2'd2) state_in = rgbc_pkg::ST_DIV;
         end
         rgbc_pkg::ST_DIV: begin
            if (step_ff == 4'd15) state_in = rgbc_pkg::ST_OUT;
         end
         rgbc_pkg::ST_OUT: begin
            if (out_free) state_in = rgbc_pkg::ST_IDLE;
         end
         default: state_in = rgbc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbc_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // window columns, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
               win_ff[i][j] <= '0;
      end else if (state_ff == rgbc_pkg::ST_READ) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1][0] <= e_rd;
         win_ff[1][1] <= m_rd;
         win_ff[1][2] <= px_ff;
      end
   end

   assign mac_px = opnd_ff[x_ff][y_ff];
   always_comb begin
      case (y_ff)
         2'd0:    mac_coef = rgbc_pkg::coef(k_earlier_ff, x_ff);
         2'd1:    mac_coef = rgbc_pkg::coef(k_middle_ff, x_ff);
         default: mac_coef = rgbc_pkg::coef(k_later_ff, x_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      logic signed [16:0] prod;
      logic [rgbc_pkg::SUM_W-1:0] sum;
      logic [8:0] t;
      if (state_ff == rgbc_pkg::ST_IDLE && req_xfer) begin
         px_ff <= req_port.pixel_word[RWD-1:0];
      end
      case (state_ff)
         rgbc_pkg::ST_READ: begin
            opnd_ff[0] <= win_ff[0];
            opnd_ff[1] <= win_ff[1];
            opnd_ff[2][0] <= e_rd;
            opnd_ff[2][1] <= m_rd;
            opnd_ff[2][2] <= px_ff;
            last_ff <= last_col && last_row;
            x_ff <= 2'd0;
            y_ff <= 2'd0;
            for (int c = 0; c < 3; c++) acc_ff[c] <= '0;
         end
         rgbc_pkg::ST_MAC: begin
            for (int c = 0; c < 3; c++) begin
               prod = $signed({1'b0, mac_px[c*8 +: 8]}) * mac_coef;
               sum  = acc_ff[c] + prod[15:0];
               acc_ff[c] <= sum;
               if (x_ff == 2'd2 && y_ff == 2'd2) begin
                  rem_ff[c] <= '0;
                  // magnitude of the wrapped sum
                  dq_ff[c]  <= sum[rgbc_pkg::SUM_W-1] ? (~sum + 16'd1) : sum;
               end
            end
            if (y_ff == 2'd2) begin
               y_ff <= 2'd0;
               x_ff <= x_ff + 2'd1;
            end else begin
               y_ff <= y_ff + 2'd1;
            end
            if (x_ff == 2'd2 && y_ff == 2'd2) begin
               step_ff <= '0;
            end
         end
         rgbc_pkg::ST_DIV: begin
            step_ff <= step_ff + 4'd1;
            for (int c = 0; c < 3; c++) begin
               t = {rem_ff[c], dq_ff[c][15]};
               if (t >= {1'b0, d_eff}) begin
                  rem_ff[c] <= 8'(t - {1'b0, d_eff});
                  dq_ff[c]  <= {dq_ff[c][14:0], 1'b1};
               end else begin
                  rem_ff[c] <= t[7:0];
                  dq_ff[c]  <= {dq_ff[c][14:0], 1'b0};
               end
            end
         end
         default: ;
      endcase
   end

   // quotient of the magnitude
   logic [rgbc_pkg::SUM_W-1:0] mag_fix [3];
   always_comb begin
      for (int c = 0; c < 3; c++) mag_fix[c] = dq_ff[c];
   end

   always_ff @(posedge clock) begin
      logic signed [17:0] r;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_port.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == rgbc_pkg::ST_OUT && out_free) rsp_valid_ff <= 1'b1;
      end
      if (state_ff == rgbc_pkg::ST_OUT && out_free) begin
         for (int c = 0; c < 3; c++) begin
            r = $signed({2'b00, mag_fix[c]}) + 18'($signed(bias_ff));
            if (r < 0)            out_ff[c] <= 8'd0;
            else if (r > 18'sd255) out_ff[c] <= 8'd255;
            else                  out_ff[c] <= r[7:0];
         end
         out_last_ff <= last_ff;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.out_red    = out_ff[0];
   assign rsp_port.out_green  = out_ff[1];
   assign rsp_port.out_blue   = out_ff[2];
   assign rsp_port.frame_last = out_last_ff;
endmodule
`default_nettype wire

// ===== rtl/rgbc_checker.sv =====
// rgbc_checker: port-level assertions on rgb_conv3x3_filter_unit and its bind
// depends on the top level's ports only
`default_nettype none
module rgbc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_red,
   input wire logic       rsp_last
);
   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_last))
      else $error("stalled result changed");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("pixel taken while previous one is read back");
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !$rose(rsp_valid))
      else $error("result appeared too early after a pixel transfer");
endmodule

bind rgb_conv3x3_filter_unit rgbc_checker u_rgbc_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_port.valid), .req_ready(req_port.ready),
   .rsp_valid(rsp_port.valid), .rsp_ready(rsp_port.ready),
   .rsp_red(rsp_port.out_red), .rsp_last(rsp_port.frame_last)
);
`default_nettype wire
